### design/pmsg_pkg.sv
// Package for the plot marker stroke generator.
// Holds widths, register and marker codes, the stroke table and the small
// constant-divisor helpers. No dependencies.
package pmsg_pkg;

  localparam int COORD_BITS    = 12;
  localparam int TIC_BITS      = 8;
  localparam int KIND_BITS     = 8;
  localparam int STEP_BITS     = 4;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 12;
  localparam int CMP_BITS      = COORD_BITS + 2;

  // Register indexes of the configuration port
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_H_TIC = 2'd0,
    CFG_V_TIC = 2'd1,
    CFG_SCR_W = 2'd2,
    CFG_SCR_H = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    MK_DIAMOND  = 3'd0,
    MK_PLUS     = 3'd1,
    MK_BOX      = 3'd2,
    MK_CROSS    = 3'd3,
    MK_TRIANGLE = 3'd4,
    MK_STAR     = 3'd5
  } marker_t;

  // Horizontal offset choice for one pen command
  typedef enum logic [2:0] {
    XS_CTR     = 3'd0,
    XS_MINUS_H = 3'd1,
    XS_PLUS_H  = 3'd2,
    XS_MINUS_T = 3'd3,
    XS_PLUS_T  = 3'd4
  } xsel_t;

  // Vertical offset choice for one pen command
  typedef enum logic [2:0] {
    YS_CTR     = 3'd0,
    YS_MINUS_V = 3'd1,
    YS_PLUS_V  = 3'd2,
    YS_PLUS_T  = 3'd3,
    YS_MINUS_B = 3'd4
  } ysel_t;

  typedef struct packed {
    logic  is_move;
    xsel_t xsel;
    ysel_t ysel;
    logic  last;
  } stroke_t;

  // Controller to datapath
  typedef struct packed {
    logic                 load_in;
    logic                 load_out;
    logic [STEP_BITS-1:0] step;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic pass;
    logic last;
    logic out_free;
  } ctrl_stat_t;

  // kind mod 6 via reciprocal: q = (k * 171) >> 10 is exact for 8-bit k
  function automatic marker_t kind_mod6(input logic [KIND_BITS-1:0] k);
    logic [15:0]          prod;
    logic [5:0]           q;
    logic [KIND_BITS-1:0] rem;
    prod = 16'(k) * 16'd171;
    q    = prod[15:10];
    rem  = k - (KIND_BITS'(q) * KIND_BITS'(6));
    return marker_t'(rem[2:0]);
  endfunction

  // floor(v / 3) for v up to 511: (v * 171) >> 9
  function automatic logic [7:0] div3(input logic [8:0] v);
    logic [16:0] prod;
    prod = 17'(v) * 17'd171;
    return prod[16:9];
  endfunction

  function automatic stroke_t mk(input logic mv, input xsel_t xs, input ysel_t ys,
                                 input logic lst);
    stroke_t s;
    s.is_move = mv;
    s.xsel    = xs;
    s.ysel    = ys;
    s.last    = lst;
    return s;
  endfunction

  // Plus strokes, six commands starting at step 0
  function automatic stroke_t plus_stroke(input logic [STEP_BITS-1:0] step,
                                          input logic lst);
    stroke_t s;
    case (step)
      4'd0:    s = mk(1'b1, XS_MINUS_H, YS_CTR, 1'b0);
      4'd1:    s = mk(1'b0, XS_MINUS_H, YS_CTR, 1'b0);
      4'd2:    s = mk(1'b0, XS_PLUS_H, YS_CTR, 1'b0);
      4'd3:    s = mk(1'b1, XS_CTR, YS_MINUS_V, 1'b0);
      4'd4:    s = mk(1'b0, XS_CTR, YS_MINUS_V, 1'b0);
      default: s = mk(1'b0, XS_CTR, YS_PLUS_V, lst);
    endcase
    return s;
  endfunction

  // X strokes, six commands starting at step 0
  function automatic stroke_t cross_stroke(input logic [STEP_BITS-1:0] step);
    stroke_t s;
    case (step)
      4'd0:    s = mk(1'b1, XS_MINUS_H, YS_MINUS_V, 1'b0);
      4'd1:    s = mk(1'b0, XS_MINUS_H, YS_MINUS_V, 1'b0);
      4'd2:    s = mk(1'b0, XS_PLUS_H, YS_PLUS_V, 1'b0);
      4'd3:    s = mk(1'b1, XS_MINUS_H, YS_PLUS_V, 1'b0);
      4'd4:    s = mk(1'b0, XS_MINUS_H, YS_PLUS_V, 1'b0);
      default: s = mk(1'b0, XS_PLUS_H, YS_MINUS_V, 1'b1);
    endcase
    return s;
  endfunction

  // Stroke table: command number step of marker kind
  function automatic stroke_t stroke_lookup(input marker_t kind,
                                            input logic [STEP_BITS-1:0] step);
    stroke_t s;
    case (kind)
      MK_DIAMOND: begin
        case (step)
          4'd0:    s = mk(1'b1, XS_MINUS_H, YS_CTR, 1'b0);
          4'd1:    s = mk(1'b0, XS_CTR, YS_MINUS_V, 1'b0);
          4'd2:    s = mk(1'b0, XS_PLUS_H, YS_CTR, 1'b0);
          4'd3:    s = mk(1'b0, XS_CTR, YS_PLUS_V, 1'b0);
          4'd4:    s = mk(1'b0, XS_MINUS_H, YS_CTR, 1'b0);
          4'd5:    s = mk(1'b1, XS_CTR, YS_CTR, 1'b0);
          default: s = mk(1'b0, XS_CTR, YS_CTR, 1'b1);
        endcase
      end
      MK_PLUS: s = plus_stroke(step, 1'b1);
      MK_BOX: begin
        case (step)
          4'd0:    s = mk(1'b1, XS_MINUS_H, YS_MINUS_V, 1'b0);
          4'd1:    s = mk(1'b0, XS_PLUS_H, YS_MINUS_V, 1'b0);
          4'd2:    s = mk(1'b0, XS_PLUS_H, YS_PLUS_V, 1'b0);
          4'd3:    s = mk(1'b0, XS_MINUS_H, YS_PLUS_V, 1'b0);
          4'd4:    s = mk(1'b0, XS_MINUS_H, YS_MINUS_V, 1'b0);
          4'd5:    s = mk(1'b1, XS_CTR, YS_CTR, 1'b0);
          default: s = mk(1'b0, XS_CTR, YS_CTR, 1'b1);
        endcase
      end
      MK_CROSS: s = cross_stroke(step);
      MK_TRIANGLE: begin
        case (step)
          4'd0:    s = mk(1'b1, XS_CTR, YS_PLUS_T, 1'b0);
          4'd1:    s = mk(1'b0, XS_MINUS_T, YS_MINUS_B, 1'b0);
          4'd2:    s = mk(1'b0, XS_PLUS_T, YS_MINUS_B, 1'b0);
          4'd3:    s = mk(1'b0, XS_CTR, YS_PLUS_T, 1'b0);
          4'd4:    s = mk(1'b1, XS_CTR, YS_CTR, 1'b0);
          default: s = mk(1'b0, XS_CTR, YS_CTR, 1'b1);
        endcase
      end
      default: begin
        // star: plus then X
        if (step < 4'd6) begin
          s = plus_stroke(step, 1'b0);
        end else begin
          s = cross_stroke(step - 4'd6);
        end
      end
    endcase
    return s;
  endfunction

endpackage

### design/pmsg_ctrl.sv
// Controller of the plot marker stroke generator.
// Sequences accept, border check and one pen command per step; uses pmsg_pkg.
module pmsg_ctrl
  import pmsg_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  ctrl_stat_t stat,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EVAL = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t               state, state_next;
  logic [STEP_BITS-1:0] step, step_next;

  assign in_ready = (state == ST_IDLE);

  // Next state and command decode
  always_comb begin
    state_next   = state;
    step_next    = step;
    cmd.load_in  = 1'b0;
    cmd.load_out = 1'b0;
    cmd.step     = step;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = ST_EVAL;
        end
      end
      ST_EVAL: begin
        step_next  = '0;
        state_next = stat.pass ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          if (stat.last) begin
            state_next = ST_IDLE;
          end else begin
            step_next = step + 1'b1;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Hold state and step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

endmodule

### design/pmsg_datapath.sv
// Datapath of the plot marker stroke generator.
// Holds configuration, the captured point, offsets and the output register;
// uses pmsg_pkg.
module pmsg_datapath
  import pmsg_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  input  logic [COORD_BITS-1:0]    in_pos_x,
  input  logic [COORD_BITS-1:0]    in_pos_y,
  input  logic [KIND_BITS-1:0]     in_kind,
  input  ctrl_cmd_t                cmd,
  output ctrl_stat_t               stat,
  input  logic                     out_ready,
  output logic                     out_valid,
  output logic                     out_is_move,
  output logic [COORD_BITS-1:0]    out_x,
  output logic [COORD_BITS-1:0]    out_y,
  output logic                     out_last
);

  logic [TIC_BITS-1:0]   h_tic_size, v_tic_size;
  logic [COORD_BITS-1:0] screen_width, screen_height;

  logic [COORD_BITS-1:0] pos_x, pos_y;
  marker_t               kind;
  logic [TIC_BITS-2:0]   hh, hv;
  logic [7:0]            th, tv, bv;

  logic signed [CMP_BITS-1:0] lim_x, lim_y, sx, sy;
  logic                       border_ok;
  stroke_t                    cur;
  logic [COORD_BITS-1:0]      nx, ny;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      h_tic_size    <= TIC_BITS'(11);
      v_tic_size    <= TIC_BITS'(11);
      screen_width  <= COORD_BITS'(1024);
      screen_height <= COORD_BITS'(780);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_H_TIC: h_tic_size    <= cfg_data[TIC_BITS-1:0];
        CFG_V_TIC: v_tic_size    <= cfg_data[TIC_BITS-1:0];
        CFG_SCR_W: screen_width  <= cfg_data[COORD_BITS-1:0];
        CFG_SCR_H: screen_height <= cfg_data[COORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Capture the point and its offsets
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      pos_x <= in_pos_x;
      pos_y <= in_pos_y;
      kind  <= kind_mod6(in_kind);
      hh    <= h_tic_size[TIC_BITS-1:1];
      hv    <= v_tic_size[TIC_BITS-1:1];
      th    <= div3({h_tic_size[TIC_BITS-1:1], 2'b00});
      tv    <= div3({v_tic_size[TIC_BITS-1:1], 2'b00});
      bv    <= div3({1'b0, v_tic_size[TIC_BITS-1:1], 1'b0});
    end
  end

  // Border test, signed so that a tiny screen rejects every point
  always_comb begin
    sx    = $signed({2'b00, pos_x});
    sy    = $signed({2'b00, pos_y});
    lim_x = $signed({2'b00, screen_width}) - $signed(CMP_BITS'(h_tic_size));
    lim_y = $signed({2'b00, screen_height}) - $signed(CMP_BITS'(v_tic_size));
    border_ok = (pos_x >= COORD_BITS'(h_tic_size)) && (pos_y >= COORD_BITS'(v_tic_size)) &&
                (sx < lim_x) && (sy < lim_y);
  end

  // Current pen command from the stroke table
  always_comb begin
    cur = stroke_lookup(kind, cmd.step);
    case (cur.xsel)
      XS_MINUS_H: nx = pos_x - COORD_BITS'(hh);
      XS_PLUS_H:  nx = pos_x + COORD_BITS'(hh);
      XS_MINUS_T: nx = pos_x - COORD_BITS'(th);
      XS_PLUS_T:  nx = pos_x + COORD_BITS'(th);
      default:    nx = pos_x;
    endcase
    case (cur.ysel)
      YS_MINUS_V: ny = pos_y - COORD_BITS'(hv);
      YS_PLUS_V:  ny = pos_y + COORD_BITS'(hv);
      YS_PLUS_T:  ny = pos_y + COORD_BITS'(tv);
      YS_MINUS_B: ny = pos_y - COORD_BITS'(bv);
      default:    ny = pos_y;
    endcase
  end

  // Status back to the controller
  assign stat = '{pass: border_ok, last: cur.last, out_free: (!out_valid || out_ready)};

  // Output register: load a command, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_is_move <= cur.is_move;
      out_x       <= nx;
      out_y       <= ny;
      out_last    <= cur.last;
    end
  end

endmodule

### design/plot_marker_stroke_generator.sv
// Plot marker stroke generator, top level.
// Joins pmsg_ctrl and pmsg_datapath; uses pmsg_pkg.
//
// Usage:
//   The slave stream takes one marker per item: centre position and kind
//   (kind taken modulo 6: diamond, plus, box, X, triangle, star). The master
//   stream returns the pen commands of that marker, one per item, with tlast
//   on the final command and tuser high for a move, low for a draw.
//   A centre on or near the tic-wide screen border yields no commands.
//   The configuration channel writes tic sizes and screen extents; write it
//   only while the block is idle. cfg_ready is always high.
// Timing:
//   One marker at a time. After acceptance the EVAL state does the border test,
//   then the sequencer steps the stroke table, one command per cycle unless a
//   low m_tready holds the output register, through which every command passes.
//   A rejected point goes from the border test straight back to idle.
//   s_tready is high only while the sequencer is idle; the last command may
//   still sit in the output register while the next marker is taken.
// Reset: rst (synchronous) returns the sequencer to idle, empties the output
//   register and restores the default configuration.
// Stall: a low m_tready holds the current command and pauses the sequencer.
module plot_marker_stroke_generator
  import pmsg_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [31:0]              s_tdata,   // pos_x[11:0], pos_y[23:12], marker_kind[31:24]
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [23:0]              m_tdata,   // target_x[11:0], target_y[23:12]
  output logic                     m_tuser,   // is_move
  output logic                     m_tlast,   // last_command
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  ctrl_cmd_t             cmd;
  ctrl_stat_t            stat;
  logic [COORD_BITS-1:0] tx, ty;

  assign cfg_ready = 1'b1;

  pmsg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pmsg_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_pos_x    (s_tdata[11:0]),
    .in_pos_y    (s_tdata[23:12]),
    .in_kind     (s_tdata[31:24]),
    .cmd         (cmd),
    .stat        (stat),
    .out_ready   (m_tready),
    .out_valid   (m_tvalid),
    .out_is_move (m_tuser),
    .out_x       (tx),
    .out_y       (ty),
    .out_last    (m_tlast)
  );

  assign m_tdata = {ty, tx};

endmodule

### dv/plot_marker_stroke_generator_tb.sv
// Self-checking testbench for plot_marker_stroke_generator. Streams marker items
// through random idle and stall gaps across several register settings, checking
// each pen command against a local stroke predictor or a typed table. Uses pmsg_pkg.
module plot_marker_stroke_generator_tb;
  import pmsg_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int HALF_PERIOD   = 5;
  localparam int RESET_CYCLES  = 9;
  localparam int MAX_GAP       = 12;
  localparam int SETTLE_CYCLES = 16;   // covers a rejected point still in flight
  localparam int LONG_STALL    = 300;
  localparam int STALL_AT      = 100;
  localparam int QUIET_LIMIT   = 2000;
  localparam int MAX_REPORTS   = 10;
  localparam int MARKER_KINDS  = 6;

  typedef struct packed {
    logic                  is_move;
    logic [COORD_BITS-1:0] tx;
    logic [COORD_BITS-1:0] ty;
    logic                  last;
  } pen_cmd_t;

  // How a directed row gets its expected commands
  typedef enum logic [1:0] {
    BY_PREDICTOR,
    TYPED_DIAMOND,
    TYPED_NONE
  } row_check_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [KIND_BITS-1:0]  kind;
    row_check_t            how;
  } marker_row_t;

  typedef struct packed {
    logic [CFG_DATA_BITS-1:0] h_tic;
    logic [CFG_DATA_BITS-1:0] v_tic;
    logic [CFG_DATA_BITS-1:0] scr_w;
    logic [CFG_DATA_BITS-1:0] scr_h;
    logic [7:0]               items;
  } settings_t;

  // Directed markers under the reset settings: tic 11, screen 1024 x 780
  localparam marker_row_t DIRECTED [19] = '{
    '{12'd100,  12'd200,  8'd0,   TYPED_DIAMOND},
    '{12'd100,  12'd200,  8'd1,   BY_PREDICTOR},
    '{12'd100,  12'd200,  8'd2,   BY_PREDICTOR},
    '{12'd100,  12'd200,  8'd3,   BY_PREDICTOR},
    '{12'd100,  12'd200,  8'd4,   BY_PREDICTOR},
    '{12'd100,  12'd200,  8'd5,   BY_PREDICTOR},
    '{12'd11,   12'd11,   8'd2,   BY_PREDICTOR},
    '{12'd1012, 12'd768,  8'd5,   BY_PREDICTOR},
    '{12'd10,   12'd100,  8'd0,   TYPED_NONE},
    '{12'd100,  12'd10,   8'd1,   TYPED_NONE},
    '{12'd1013, 12'd100,  8'd2,   TYPED_NONE},
    '{12'd100,  12'd769,  8'd3,   TYPED_NONE},
    '{12'd4095, 12'd4095, 8'd255, TYPED_NONE},
    '{12'd0,    12'd0,    8'd0,   TYPED_NONE},
    '{12'd500,  12'd400,  8'd255, BY_PREDICTOR},
    '{12'd500,  12'd400,  8'd6,   BY_PREDICTOR},
    '{12'd500,  12'd400,  8'd250, BY_PREDICTOR},
    '{12'd2047, 12'd384,  8'd128, TYPED_NONE},
    '{12'd1012, 12'd11,   8'd4,   BY_PREDICTOR}
  };

  // Diamond at (100, 200) with half-tics of 5
  localparam pen_cmd_t DIAMOND_AT_RESET [7] = '{
    '{1'b1, 12'd95,  12'd200, 1'b0},
    '{1'b0, 12'd100, 12'd195, 1'b0},
    '{1'b0, 12'd105, 12'd200, 1'b0},
    '{1'b0, 12'd100, 12'd205, 1'b0},
    '{1'b0, 12'd95,  12'd200, 1'b0},
    '{1'b1, 12'd100, 12'd200, 1'b0},
    '{1'b0, 12'd100, 12'd200, 1'b1}
  };

  // Register settings walked after the directed part; tic data above 8 bits is dropped
  localparam settings_t PHASES [6] = '{
    '{12'hFFF, 12'hFFF, 12'd4095, 12'd4095, 8'd40},
    '{12'd1,   12'd1,   12'd4095, 12'd4095, 8'd35},
    '{12'd0,   12'd0,   12'd4095, 12'd4095, 8'd25},
    '{12'h164, 12'd3,   12'd200,  12'd0,    8'd8},
    '{12'd37,  12'd90,  12'd3000, 12'd2000, 8'd35},
    '{12'd254, 12'd1,   12'd4095, 12'd600,  8'd30}
  };

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     s_tvalid = 1'b0;
  logic                     s_tready;
  logic [31:0]              s_tdata = '0;    // pos_x[11:0], pos_y[23:12], marker_kind[31:24]
  logic                     m_tvalid;
  logic                     m_tready = 1'b0;
  logic [23:0]              m_tdata;         // target_x[11:0], target_y[23:12]
  logic                     m_tuser;         // is_move
  logic                     m_tlast;         // last_command
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_BITS-1:0]  cfg_index = CFG_H_TIC;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  // Local copy of the registers
  logic [TIC_BITS-1:0]   tic_h = 8'd11;
  logic [TIC_BITS-1:0]   tic_v = 8'd11;
  logic [COORD_BITS-1:0] scr_w = 12'd1024;
  logic [COORD_BITS-1:0] scr_h = 12'd780;

  pen_cmd_t pending_strokes [$];
  int       mismatch_count = 0;
  int       strokes_taken = 0;
  bit       sender_burst = 1'b0;
  bit       receiver_burst = 1'b0;

  plot_marker_stroke_generator u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  function automatic void add_stroke(input logic mv, input int x, input int y);
    pen_cmd_t c;
    c.is_move = mv;
    c.tx      = COORD_BITS'(x);
    c.ty      = COORD_BITS'(y);
    c.last    = 1'b0;
    pending_strokes.push_back(c);
  endfunction

  function automatic void add_plus(input int x, input int y, input int hh, input int hv);
    add_stroke(1'b1, x - hh, y);
    add_stroke(1'b0, x - hh, y);
    add_stroke(1'b0, x + hh, y);
    add_stroke(1'b1, x, y - hv);
    add_stroke(1'b0, x, y - hv);
    add_stroke(1'b0, x, y + hv);
  endfunction

  function automatic void add_cross(input int x, input int y, input int hh, input int hv);
    add_stroke(1'b1, x - hh, y - hv);
    add_stroke(1'b0, x - hh, y - hv);
    add_stroke(1'b0, x + hh, y + hv);
    add_stroke(1'b1, x - hh, y + hv);
    add_stroke(1'b0, x - hh, y + hv);
    add_stroke(1'b0, x + hh, y - hv);
  endfunction

  // Append the pen commands of one marker to the pending list
  function automatic void predict_strokes(input logic [COORD_BITS-1:0] px,
                                          input logic [COORD_BITS-1:0] py,
                                          input logic [KIND_BITS-1:0] kind);
    int       x, y, ht, vt, hh, hv, th, tv, bv, start;
    marker_t  shape;
    pen_cmd_t tail;
    x     = int'(px);
    y     = int'(py);
    ht    = int'(tic_h);
    vt    = int'(tic_v);
    hh    = ht / 2;
    hv    = vt / 2;
    th    = (4 * hh) / 3;
    tv    = (4 * hv) / 3;
    bv    = (2 * hv) / 3;
    shape = marker_t'(3'(int'(kind) % MARKER_KINDS));
    start = pending_strokes.size();
    // Drop points on or near the tic-wide border
    if (x < ht || y < vt || x >= int'(scr_w) - ht || y >= int'(scr_h) - vt) return;
    case (shape)
      MK_DIAMOND: begin
        add_stroke(1'b1, x - hh, y);
        add_stroke(1'b0, x, y - hv);
        add_stroke(1'b0, x + hh, y);
        add_stroke(1'b0, x, y + hv);
        add_stroke(1'b0, x - hh, y);
        add_stroke(1'b1, x, y);
        add_stroke(1'b0, x, y);
      end
      MK_PLUS: add_plus(x, y, hh, hv);
      MK_BOX: begin
        add_stroke(1'b1, x - hh, y - hv);
        add_stroke(1'b0, x + hh, y - hv);
        add_stroke(1'b0, x + hh, y + hv);
        add_stroke(1'b0, x - hh, y + hv);
        add_stroke(1'b0, x - hh, y - hv);
        add_stroke(1'b1, x, y);
        add_stroke(1'b0, x, y);
      end
      MK_CROSS: add_cross(x, y, hh, hv);
      MK_TRIANGLE: begin
        add_stroke(1'b1, x, y + tv);
        add_stroke(1'b0, x - th, y - bv);
        add_stroke(1'b0, x + th, y - bv);
        add_stroke(1'b0, x, y + tv);
        add_stroke(1'b1, x, y);
        add_stroke(1'b0, x, y);
      end
      default: begin
        add_plus(x, y, hh, hv);
        add_cross(x, y, hh, hv);
      end
    endcase
    // Mark the final command of this marker
    if (pending_strokes.size() > start) begin
      tail      = pending_strokes.pop_back();
      tail.last = 1'b1;
      pending_strokes.push_back(tail);
    end
  endfunction

  // Pick a coordinate: mostly inside the drawable area, some on its edges, some anywhere
  function automatic logic [COORD_BITS-1:0] draw_coord(input int tic, input int extent);
    int lo, hi, r;
    lo = tic;
    hi = extent - tic - 1;
    r  = $urandom_range(0, 99);
    if (hi >= lo && r < 75) return COORD_BITS'($urandom_range(hi, lo));
    if (r < 88) begin
      case ($urandom_range(0, 3))
        0:       return COORD_BITS'(lo - 1);
        1:       return COORD_BITS'(lo);
        2:       return COORD_BITS'(hi);
        default: return COORD_BITS'(hi + 1);
      endcase
    end
    return COORD_BITS'($urandom_range(0, 4095));
  endfunction

  task automatic write_register(input cfg_reg_t idx, input logic [CFG_DATA_BITS-1:0] value,
                                input bit more);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      CFG_H_TIC: tic_h = value[TIC_BITS-1:0];
      CFG_V_TIC: tic_v = value[TIC_BITS-1:0];
      CFG_SCR_W: scr_w = value;
      default:   scr_h = value;
    endcase
    // Hold valid high across back-to-back writes
    if (!more) cfg_valid <= 1'b0;
  endtask

  task automatic apply_settings(input settings_t s);
    write_register(CFG_H_TIC, s.h_tic, 1'b1);
    write_register(CFG_V_TIC, s.v_tic, 1'b1);
    write_register(CFG_SCR_W, s.scr_w, 1'b1);
    write_register(CFG_SCR_H, s.scr_h, 1'b0);
  endtask

  // Offer one marker after a random gap, then log its expected commands
  task automatic send_marker(input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y,
                             input logic [KIND_BITS-1:0] kind, input row_check_t how);
    int gap;
    if ($urandom_range(0, 15) == 0) sender_burst = !sender_burst;
    gap = sender_burst ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tdata  <= {kind, y, x};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (s_tready !== 1'b1);
    case (how)
      BY_PREDICTOR:  predict_strokes(x, y, kind);
      TYPED_DIAMOND: foreach (DIAMOND_AT_RESET[i]) pending_strokes.push_back(DIAMOND_AT_RESET[i]);
      default:       ;
    endcase
  endtask

  task automatic send_random(input int count, input int pause_at);
    logic [COORD_BITS-1:0] x, y;
    for (int n = 0; n < count; n++) begin
      x = draw_coord(int'(tic_h), int'(scr_w));
      y = draw_coord(int'(tic_v), int'(scr_h));
      send_marker(x, y, KIND_BITS'($urandom_range(0, 255)), BY_PREDICTOR);
      if (n == pause_at) wait_idle();
    end
  endtask

  // Drop valid, wait for every pending command, then let the block settle
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_strokes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Main sequence
  initial begin : stimulus
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    foreach (DIRECTED[i]) send_marker(DIRECTED[i].x, DIRECTED[i].y, DIRECTED[i].kind,
                                      DIRECTED[i].how);
    send_random(30, -1);
    wait_idle();
    foreach (PHASES[p]) begin
      apply_settings(PHASES[p]);
      send_random(int'(PHASES[p].items), (p == 1) ? 15 : -1);
      wait_idle();
    end
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Take pen commands with random stalls and check each against the oldest expectation
  initial begin : receiver
    int       gap;
    pen_cmd_t seen, want;
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 15) == 0) receiver_burst = !receiver_burst;
      gap = receiver_burst ? 0 : $urandom_range(0, MAX_GAP);
      // Hold off once for a long stretch so the block fills and stalls its input
      if (strokes_taken == STALL_AT) gap = LONG_STALL;
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (m_tvalid !== 1'b1);
      strokes_taken++;
      seen = '{m_tuser, m_tdata[11:0], m_tdata[23:12], m_tlast};
      if (pending_strokes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected command: move %0b x %0d y %0d last %0b",
                   seen.is_move, seen.tx, seen.ty, seen.last);
      end else begin
        want = pending_strokes.pop_front();
        if (seen.is_move !== want.is_move || seen.tx !== want.tx ||
            seen.ty !== want.ty || seen.last !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("command mismatch: expected move %0b x %0d y %0d last %0b, got move %0b x %0d y %0d last %0b",
                     want.is_move, want.tx, want.ty, want.last,
                     seen.is_move, seen.tx, seen.ty, seen.last);
        end
      end
    end
  end

  // End the run when no item moves on any channel for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Mismatches found");
    $finish;
  end

endmodule

### plot_marker_stroke_generator.f
design/pmsg_pkg.sv
design/pmsg_ctrl.sv
design/pmsg_datapath.sv
design/plot_marker_stroke_generator.sv
dv/plot_marker_stroke_generator_tb.sv
